### rtl/triangle_clip_transform_outcode_unit_assert.svh
// Assertion macros used by the port-level checker of the triangle clip unit.
`ifndef TRIANGLE_CLIP_TRANSFORM_OUTCODE_UNIT_ASSERT_SVH
`define TRIANGLE_CLIP_TRANSFORM_OUTCODE_UNIT_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define TCTO_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define TCTO_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/tcto_pkg.sv
// Package with the types, constants and float helpers of the triangle clip unit.
package tcto_pkg;

  localparam int unsigned NumRegs  = 8;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 64;
  localparam int unsigned FmaLat   = 5;

  localparam logic [1:0]  FirstSlot = 2'd0;
  localparam logic [1:0]  MidSlot   = 2'd1;
  localparam logic [1:0]  LastSlot  = 2'd2;
  localparam logic [5:0]  AllPlanes = 6'h3f;
  localparam logic [31:0] CanonNan  = 32'h7fc0_0000;
  localparam logic [31:0] PosZero   = 32'h0000_0000;

  typedef struct packed {
    logic [31:0] v0_x;
    logic [31:0] v0_y;
    logic [31:0] v0_z;
    logic [31:0] v1_x;
    logic [31:0] v1_y;
    logic [31:0] v1_z;
    logic [31:0] v2_x;
    logic [31:0] v2_y;
    logic [31:0] v2_z;
    logic        depth_zero_to_one;
  } in_t;

  typedef struct packed {
    logic [1:0]  vertex_slot;
    logic [31:0] clip_x;
    logic [31:0] clip_y;
    logic [31:0] clip_z;
    logic [31:0] clip_w;
    logic [5:0]  outcode;
    logic [5:0]  planes_or;
    logic [5:0]  planes_and;
    logic        last_vertex;
  } out_t;

  function automatic logic is_nan(input logic [31:0] f);
    return (f[30:23] == 8'hff) && (f[22:0] != 23'd0);
  endfunction

  // Ordered less-than on float32 bit patterns; false when either side is NaN.
  function automatic logic flt_lt(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] ka;
    logic [31:0] kb;
    ka = a[31] ? ~a : {1'b1, a[30:0]};
    kb = b[31] ? ~b : {1'b1, b[30:0]};
    if (is_nan(a) || is_nan(b)) begin
      return 1'b0;
    end
    if ((a[30:0] == 31'd0) && (b[30:0] == 31'd0)) begin
      return 1'b0;
    end
    return ka < kb;
  endfunction

endpackage

### rtl/triangle_clip_transform_outcode_unit.sv
// Top level of the triangle clip-space transform and outcode unit.
// One request carries a triangle; it yields three results, one per vertex, in vertex order,
// and one vertex enters the pipeline each cycle while no result waits on a stall. The
// single result channel sets that rate. Each vertex runs through four row lanes of three
// chained five-stage fused multiply-add units. A request is held in the triangle register;
// each vertex then passes the three chained units and the output register, in vertex order.
// The whole pipeline holds while a result waits on a stall.
// Matrix registers must be written only while the unit is idle; the block does not enforce it.
module triangle_clip_transform_outcode_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  tcto_pkg::in_t                   in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output tcto_pkg::out_t                  out_data_o,
  input  logic                            cfg_we_i,
  input  logic [tcto_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [tcto_pkg::CfgDataW-1:0]   cfg_wdata_i
);

  localparam int unsigned Depth = 3 * tcto_pkg::FmaLat;

  logic [tcto_pkg::CfgDataW-1:0] mat_q [tcto_pkg::NumRegs];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < tcto_pkg::NumRegs; i++) begin
        mat_q[i] <= '0;
      end
    end else if (cfg_we_i && (cfg_idx_i < tcto_pkg::CfgIdxW'(tcto_pkg::NumRegs))) begin
      mat_q[cfg_idx_i[2:0]] <= cfg_wdata_i;
    end
  end

  logic en;
  logic out_valid_q;
  assign en = !out_valid_q || !out_stall_i;

  // Triangle holding register that hands out one vertex per cycle while the pipeline is not held.
  tcto_pkg::in_t tri_q;
  logic          tri_vld_q;
  logic [1:0]    idx_q;
  logic          take, in_ready, in_acc;
  logic [31:0]   vx, vy, vz;

  assign take     = en && tri_vld_q;
  assign in_ready = !tri_vld_q || (take && (idx_q == tcto_pkg::LastSlot));
  assign in_acc   = in_valid_i && in_ready;
  assign in_stall_o = !in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tri_vld_q <= 1'b0;
      idx_q     <= tcto_pkg::FirstSlot;
    end else if (in_acc) begin
      tri_vld_q <= 1'b1;
      idx_q     <= tcto_pkg::FirstSlot;
    end else if (take && (idx_q == tcto_pkg::LastSlot)) begin
      tri_vld_q <= 1'b0;
    end else if (take) begin
      idx_q <= idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      tri_q <= in_data_i;
    end
  end

  always_comb begin
    case (idx_q)
      tcto_pkg::FirstSlot: begin
        vx = tri_q.v0_x;
        vy = tri_q.v0_y;
        vz = tri_q.v0_z;
      end
      tcto_pkg::MidSlot: begin
        vx = tri_q.v1_x;
        vy = tri_q.v1_y;
        vz = tri_q.v1_z;
      end
      default: begin
        vx = tri_q.v2_x;
        vy = tri_q.v2_y;
        vz = tri_q.v2_z;
      end
    endcase
  end

  // Side lines that travel with each vertex through the multiply-add lanes.
  logic [31:0] y_q    [tcto_pkg::FmaLat];
  logic [31:0] z_q    [2 * tcto_pkg::FmaLat];
  logic [1:0]  slot_q [Depth];
  logic        mode_q [Depth];
  logic        vld_q  [Depth];

  always_ff @(posedge clk_i) begin
    if (en) begin
      y_q[0]    <= vy;
      z_q[0]    <= vz;
      slot_q[0] <= idx_q;
      mode_q[0] <= tri_q.depth_zero_to_one;
      for (int i = 1; i < tcto_pkg::FmaLat; i++) begin
        y_q[i] <= y_q[i-1];
      end
      for (int i = 1; i < 2 * tcto_pkg::FmaLat; i++) begin
        z_q[i] <= z_q[i-1];
      end
      for (int i = 1; i < Depth; i++) begin
        slot_q[i] <= slot_q[i-1];
        mode_q[i] <= mode_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) begin
        vld_q[i] <= 1'b0;
      end
    end else if (en) begin
      vld_q[0] <= tri_vld_q;
      for (int i = 1; i < Depth; i++) begin
        vld_q[i] <= vld_q[i-1];
      end
    end
  end

  logic [31:0] clip [4];

  for (genvar r = 0; r < 4; r++) begin : g_row
    logic [31:0] m0, m1, m2, m3, acc0, acc1;
    assign m0 = (r % 2 == 1) ? mat_q[0 + r / 2][63:32] : mat_q[0 + r / 2][31:0];
    assign m1 = (r % 2 == 1) ? mat_q[2 + r / 2][63:32] : mat_q[2 + r / 2][31:0];
    assign m2 = (r % 2 == 1) ? mat_q[4 + r / 2][63:32] : mat_q[4 + r / 2][31:0];
    assign m3 = (r % 2 == 1) ? mat_q[6 + r / 2][63:32] : mat_q[6 + r / 2][31:0];

    tcto_fma u_fma_x (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (m0),
      .b_i   (vx),
      .c_i   (m3),
      .res_o (acc0)
    );

    tcto_fma u_fma_y (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (m1),
      .b_i   (y_q[tcto_pkg::FmaLat-1]),
      .c_i   (acc0),
      .res_o (acc1)
    );

    tcto_fma u_fma_z (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (m2),
      .b_i   (z_q[2*tcto_pkg::FmaLat-1]),
      .c_i   (acc1),
      .res_o (clip[r])
    );
  end

  // Outcode and triangle plane summary on the output register.
  logic [31:0]    neg_w;
  logic [5:0]     code;
  logic [5:0]     act_d, com_d;
  logic [5:0]     act_q, com_q;
  logic [1:0]     slot_l;
  logic           is_last;
  tcto_pkg::out_t out_d, out_q;

  always_comb begin
    slot_l  = slot_q[Depth-1];
    is_last = (slot_l == tcto_pkg::LastSlot);
    neg_w   = {~clip[3][31], clip[3][30:0]};
    code[0] = tcto_pkg::flt_lt(clip[0], neg_w);
    code[1] = tcto_pkg::flt_lt(clip[3], clip[0]);
    code[2] = tcto_pkg::flt_lt(clip[1], neg_w);
    code[3] = tcto_pkg::flt_lt(clip[3], clip[1]);
    code[4] = mode_q[Depth-1] ? tcto_pkg::flt_lt(clip[2], tcto_pkg::PosZero)
                              : tcto_pkg::flt_lt(clip[2], neg_w);
    code[5] = tcto_pkg::flt_lt(clip[3], clip[2]);
    if (slot_l == tcto_pkg::FirstSlot) begin
      act_d = code;
      com_d = code & tcto_pkg::AllPlanes;
    end else begin
      act_d = act_q | code;
      com_d = com_q & code;
    end
    out_d.vertex_slot = slot_l;
    out_d.clip_x      = clip[0];
    out_d.clip_y      = clip[1];
    out_d.clip_z      = clip[2];
    out_d.clip_w      = clip[3];
    out_d.outcode     = code;
    out_d.planes_or   = is_last ? act_d : 6'd0;
    out_d.planes_and  = is_last ? com_d : 6'd0;
    out_d.last_vertex = is_last;
  end

  always_ff @(posedge clk_i) begin
    if (en && vld_q[Depth-1]) begin
      out_q <= out_d;
      act_q <= act_d;
      com_q <= com_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vld_q[Depth-1];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/tcto_fma.sv
// Five-stage float32 fused multiply-add with a single round-to-nearest-even.
module tcto_fma (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic [31:0] c_i,
  output logic [31:0] res_o
);

  // Stage 1: unpack, multiply, align the addend.
  logic [7:0]         ea_d, eb_d, ec_d;
  logic [23:0]        siga_d, sigb_d, sigc_d;
  logic               a_zero, b_zero, c_zero, a_inf, b_inf, c_inf, any_nan;
  logic               sp_d;
  logic signed [11:0] pos_d, base1_d;
  logic               hi_d;
  logic [6:0]         sh_d;
  logic [126:0]       wide_d;
  logic               spec1_d;
  logic [31:0]        specv1_d;

  logic [47:0]        prod_q;
  logic [99:0]        awin_q;
  logic               sp1_q, sub1_q, spec1_q;
  logic signed [11:0] base1_q;
  logic [31:0]        specv1_q;

  always_comb begin
    ea_d    = (a_i[30:23] == 8'd0) ? 8'd1 : a_i[30:23];
    eb_d    = (b_i[30:23] == 8'd0) ? 8'd1 : b_i[30:23];
    ec_d    = (c_i[30:23] == 8'd0) ? 8'd1 : c_i[30:23];
    siga_d  = {a_i[30:23] != 8'd0, a_i[22:0]};
    sigb_d  = {b_i[30:23] != 8'd0, b_i[22:0]};
    sigc_d  = {c_i[30:23] != 8'd0, c_i[22:0]};
    a_zero  = (a_i[30:0] == 31'd0);
    b_zero  = (b_i[30:0] == 31'd0);
    c_zero  = (c_i[30:0] == 31'd0);
    a_inf   = (a_i[30:0] == 31'h7f80_0000);
    b_inf   = (b_i[30:0] == 31'h7f80_0000);
    c_inf   = (c_i[30:0] == 31'h7f80_0000);
    any_nan = tcto_pkg::is_nan(a_i) || tcto_pkg::is_nan(b_i) || tcto_pkg::is_nan(c_i);
    sp_d    = a_i[31] ^ b_i[31];
    pos_d   = $signed({4'b0, ec_d}) + 12'sd176 - $signed({4'b0, ea_d})
              - $signed({4'b0, eb_d});
    hi_d    = (pos_d > 12'sd76);
    if (pos_d < -12'sd27) begin
      sh_d = 7'd0;
    end else if (hi_d) begin
      sh_d = 7'd103;
    end else begin
      sh_d = 7'(pos_d + 12'sd27);
    end
    wide_d  = {103'b0, sigc_d} << sh_d;
    base1_d = hi_d ? ($signed({4'b0, ec_d}) - 12'sd226)
                   : ($signed({4'b0, ea_d}) + $signed({4'b0, eb_d}) - 12'sd326);
    spec1_d  = 1'b1;
    specv1_d = tcto_pkg::CanonNan;
    if (any_nan || (a_inf && b_zero) || (b_inf && a_zero) ||
        ((a_inf || b_inf) && c_inf && (sp_d != c_i[31]))) begin
      specv1_d = tcto_pkg::CanonNan;
    end else if (a_inf || b_inf) begin
      specv1_d = {sp_d, 8'hff, 23'd0};
    end else if (c_inf) begin
      specv1_d = c_i;
    end else if (a_zero || b_zero) begin
      specv1_d = c_zero ? {sp_d & c_i[31], 31'd0} : c_i;
    end else begin
      spec1_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q   <= siga_d * sigb_d;
      awin_q   <= wide_d[126:27] | {99'b0, |wide_d[26:0]};
      sp1_q    <= sp_d;
      sub1_q   <= sp_d ^ c_i[31];
      base1_q  <= base1_d;
      spec1_q  <= spec1_d;
      specv1_q <= specv1_d;
    end
  end

  // Stage 2: add or subtract in the 101-bit window.
  logic [100:0]       pw_d, aw_d, mag2_d;
  logic               sign2_d;
  logic [100:0]       mag2_q;
  logic               sign2_q, spec2_q;
  logic signed [11:0] base2_q;
  logic [31:0]        specv2_q;

  always_comb begin
    pw_d = {27'b0, prod_q, 26'b0};
    aw_d = {1'b0, awin_q};
    if (!sub1_q) begin
      mag2_d  = pw_d + aw_d;
      sign2_d = sp1_q;
    end else if (pw_d >= aw_d) begin
      mag2_d  = pw_d - aw_d;
      sign2_d = sp1_q;
    end else begin
      mag2_d  = aw_d - pw_d;
      sign2_d = ~sp1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag2_q   <= mag2_d;
      sign2_q  <= sign2_d;
      base2_q  <= base1_q;
      spec2_q  <= spec1_q;
      specv2_q <= specv1_q;
    end
  end

  // Stage 3: leading-zero count, limited by the subnormal boundary.
  logic [6:0]         lz_d;
  logic signed [11:0] lim_d, shl3_d;
  logic [100:0]       mag3_q;
  logic               sign3_q, zero3_q, spec3_q;
  logic signed [11:0] base3_q, shl3_q;
  logic [31:0]        specv3_q;

  always_comb begin
    lz_d = 7'd101;
    for (int i = 0; i < 101; i++) begin
      if (mag2_q[i]) begin
        lz_d = 7'(100 - i);
      end
    end
    lim_d  = base2_q + 12'sd226;
    shl3_d = (lim_d < $signed({5'b0, lz_d})) ? lim_d : $signed({5'b0, lz_d});
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag3_q   <= mag2_q;
      sign3_q  <= sign2_q;
      zero3_q  <= (mag2_q == 101'd0);
      spec3_q  <= spec2_q;
      specv3_q <= specv2_q;
      base3_q  <= base2_q;
      shl3_q   <= shl3_d;
    end
  end

  // Stage 4: normalizing shift, right shift with sticky for tiny values.
  logic signed [11:0] neg_d;
  logic [6:0]         rsh_d;
  logic [227:0]       tmp_d;
  logic [100:0]       norm4_d;
  logic               st4_d;
  logic [100:0]       norm4_q;
  logic               st4_q, sign4_q, zero4_q, spec4_q;
  logic signed [11:0] exp4_q;
  logic [31:0]        specv4_q;

  always_comb begin
    neg_d = -shl3_q;
    rsh_d = (neg_d > 12'sd127) ? 7'd127 : 7'(neg_d);
    tmp_d = {mag3_q, 127'b0} >> rsh_d;
    if (!shl3_q[11]) begin
      norm4_d = mag3_q << shl3_q[6:0];
      st4_d   = 1'b0;
    end else begin
      norm4_d = tmp_d[227:127];
      st4_d   = |tmp_d[126:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      norm4_q  <= norm4_d;
      st4_q    <= st4_d;
      exp4_q   <= base3_q + 12'sd227 - shl3_q;
      sign4_q  <= sign3_q;
      zero4_q  <= zero3_q;
      spec4_q  <= spec3_q;
      specv4_q <= specv3_q;
    end
  end

  // Stage 5: round to nearest even and pack.
  logic        inc_d, ovf_d;
  logic [7:0]  efld_d;
  logic [30:0] pack_d;
  logic [31:0] res_d;
  logic [31:0] res_q;

  always_comb begin
    inc_d  = norm4_q[76] && ((|norm4_q[75:0]) || st4_q || norm4_q[77]);
    efld_d = norm4_q[100] ? exp4_q[7:0] : 8'd0;
    ovf_d  = norm4_q[100] && (exp4_q > 12'sd254);
    pack_d = {efld_d, norm4_q[99:77]} + {30'd0, inc_d};
    if (spec4_q) begin
      res_d = specv4_q;
    end else if (zero4_q) begin
      res_d = tcto_pkg::PosZero;
    end else if (ovf_d) begin
      res_d = {sign4_q, 8'hff, 23'd0};
    end else begin
      res_d = {sign4_q, pack_d};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

### rtl/tcto_checker.sv
// Port-level checker of the triangle clip unit and its bind statement.
`include "triangle_clip_transform_outcode_unit_assert.svh"

module tcto_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input tcto_pkg::out_t out_data_o
);

  `TCTO_ASSERT_NOW(a_last_slot, out_valid_o, out_data_o.last_vertex == (out_data_o.vertex_slot == tcto_pkg::LastSlot), "last flag does not match the vertex slot")
  `TCTO_ASSERT_NOW(a_mid_planes, out_valid_o && !out_data_o.last_vertex, (out_data_o.planes_or == 6'd0) && (out_data_o.planes_and == 6'd0), "plane summary set before the last vertex")
  `TCTO_ASSERT_NOW(a_plane_order, out_valid_o && out_data_o.last_vertex, ((out_data_o.planes_and & ~out_data_o.planes_or) == 6'd0) && ((out_data_o.outcode & ~out_data_o.planes_or) == 6'd0), "plane summary is inconsistent")
  `TCTO_ASSERT_NEXT(a_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o), "stalled result changed")

endmodule

bind triangle_clip_transform_outcode_unit tcto_checker u_tcto_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
